// ===== hw/rtl/pfdr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame buffer refresh package
// Sizes, command bytes, actions and the structs shared by the store, the
// refresh sequencer and the top level.
// ----------------------------------------------------------------------------
package pfdr_pkg;

    localparam int COLUMNS  = 128;
    localparam int PAGES    = 8;
    localparam int ROWS     = PAGES * 8;
    localparam int DEPTH    = COLUMNS * PAGES;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int POS_W    = $clog2(COLUMNS + 3);
    localparam int LAST_POS = COLUMNS + 2;

    localparam logic [7:0] ALL_PAGES     = 8'((1 << PAGES) - 1);
    localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
    localparam logic [7:0] COL_LOW_CMD   = 8'h00;
    localparam logic [7:0] COL_HIGH_CMD  = 8'h10;

    typedef enum logic [2:0] {
        ACT_SET_PIXEL   = 3'd0,
        ACT_CLEAR_PIXEL = 3'd1,
        ACT_CLEAR_ALL   = 3'd2,
        ACT_START       = 3'd3,
        ACT_NEXT_BYTE   = 3'd4
    } action_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wr_data;
    } mem_req_t;

    typedef struct packed {
        logic       mark;
        logic [2:0] mark_page;
        logic       start;
        logic       clear_all;
        logic       advance;
    } seq_cmd_t;

    typedef struct packed {
        logic             active;
        logic [2:0]       page;
        logic [POS_W-1:0] pos;
        logic             last;
    } seq_stat_t;

    typedef struct packed {
        logic       found;
        logic [2:0] page;
    } page_sel_t;

    function automatic page_sel_t next_page(input logic [7:0] mask, input logic [3:0] from);
        page_sel_t res;
        res = '0;
        for (int p = PAGES - 1; p >= 0; p--)
        begin
            if (4'(p) >= from && mask[p])
            begin
                res.found = 1'b1;
                res.page  = 3'(p);
            end
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [7:0] col,
                                                  input logic [2:0] page);
        return ADDR_W'(ADDR_W'(col) * ADDR_W'(PAGES) + ADDR_W'(page));
    endfunction

endpackage

// ===== hw/rtl/page_framebuffer_dirty_refresh.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame buffer with dirty-page refresh
// Monochrome frame store of columns by 8-pixel pages that streams the
// command and data bytes of the pages changed since the last refresh.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready) takes one action per item: set or
// clear a pixel, clear all, start a refresh or fetch the next stream byte.
// The output channel (out_valid, out_ready) delivers one byte per next-byte
// item while a refresh run is active; other actions give no output.
// A pixel action is one memory read, then the write back, as the single
// memory port serves both. A command byte goes straight into the output
// register when that register is free; a data byte first passes through
// the registered memory read.
// Clear all sweeps the whole store, one byte a cycle, and no item is taken
// until the sweep ends. After reset the same sweep runs and in_ready rises
// when it ends.
// When the receiver stalls, the waiting byte sits in the output register
// and further items are still taken; a second byte waits in a hold
// register and stops intake until the output register frees.
// ----------------------------------------------------------------------------
module page_framebuffer_dirty_refresh
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] action,
    input  logic [7:0] pixel_column,
    input  logic [7:0] pixel_row,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] stream_byte,
    output logic       is_data,
    output logic       last_of_refresh
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RMW   = 5'b00100,
        ST_READ  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    pfdr_pkg::mem_req_t          req;
    pfdr_pkg::seq_cmd_t          cmd;
    pfdr_pkg::seq_stat_t         stat;
    pfdr_pkg::action_t           act;
    logic                        clear_start;
    logic                        busy;
    logic [7:0]                  rd_data;
    logic                        in_acc;
    logic                        pix_ok;
    logic                        slot_free;
    logic                        is_cmd;
    logic [7:0]                  cmd_byte;
    logic [7:0]                  bit_mask;
    logic [pfdr_pkg::ADDR_W-1:0] pix_addr_reg;
    logic [pfdr_pkg::ADDR_W-1:0] pix_addr_next;
    logic [2:0]                  pix_bit_reg;
    logic [2:0]                  pix_bit_next;
    logic                        pix_set_reg;
    logic                        pix_set_next;
    logic [7:0]                  res_byte_reg;
    logic [7:0]                  res_byte_next;
    logic                        res_data_reg;
    logic                        res_data_next;
    logic                        res_last_reg;
    logic                        res_last_next;
    logic                        load;
    logic [7:0]                  load_byte;
    logic                        load_data;
    logic                        load_last;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [7:0]                  stream_byte_reg;
    logic                        is_data_reg;
    logic                        last_reg;

    pfdr_store u_store
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .clear_start (clear_start),
        .rd_data     (rd_data),
        .busy        (busy)
    );

    pfdr_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign act       = pfdr_pkg::action_t'(action);
    assign pix_ok    = (pixel_column < 8'(pfdr_pkg::COLUMNS)) &&
                       (pixel_row < 8'(pfdr_pkg::ROWS));
    assign slot_free = !out_valid_reg || out_ready;
    assign is_cmd    = (stat.pos < pfdr_pkg::POS_W'(3));
    assign bit_mask  = 8'd1 << pix_bit_reg;

    always_comb
    begin
        if (stat.pos == pfdr_pkg::POS_W'(0))
        begin
            cmd_byte = pfdr_pkg::PAGE_CMD_BASE + 8'(stat.page);
        end
        else if (stat.pos == pfdr_pkg::POS_W'(1))
        begin
            cmd_byte = pfdr_pkg::COL_LOW_CMD;
        end
        else
        begin
            cmd_byte = pfdr_pkg::COL_HIGH_CMD;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        req           = '0;
        cmd           = '0;
        clear_start   = 1'b0;
        pix_addr_next = pix_addr_reg;
        pix_bit_next  = pix_bit_reg;
        pix_set_next  = pix_set_reg;
        res_byte_next = res_byte_reg;
        res_data_next = res_data_reg;
        res_last_next = res_last_reg;
        load          = 1'b0;
        load_byte     = res_byte_reg;
        load_data     = res_data_reg;
        load_last     = res_last_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (act)
                        pfdr_pkg::ACT_SET_PIXEL, pfdr_pkg::ACT_CLEAR_PIXEL:
                        begin
                            if (pix_ok)
                            begin
                                req.rd_en     = 1'b1;
                                req.addr      = pfdr_pkg::mem_addr(pixel_column,
                                                                   pixel_row[5:3]);
                                pix_addr_next = req.addr;
                                pix_bit_next  = pixel_row[2:0];
                                pix_set_next  = (act == pfdr_pkg::ACT_SET_PIXEL);
                                cmd.mark      = 1'b1;
                                cmd.mark_page = pixel_row[5:3];
                                state_next    = ST_RMW;
                            end
                        end
                        pfdr_pkg::ACT_CLEAR_ALL:
                        begin
                            clear_start   = 1'b1;
                            cmd.clear_all = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        pfdr_pkg::ACT_START:
                        begin
                            cmd.start = 1'b1;
                        end
                        pfdr_pkg::ACT_NEXT_BYTE:
                        begin
                            if (stat.active)
                            begin
                                cmd.advance   = 1'b1;
                                res_last_next = stat.last;
                                if (is_cmd)
                                begin
                                    if (slot_free)
                                    begin
                                        load      = 1'b1;
                                        load_byte = cmd_byte;
                                        load_data = 1'b0;
                                        load_last = stat.last;
                                    end
                                    else
                                    begin
                                        res_byte_next = cmd_byte;
                                        res_data_next = 1'b0;
                                        state_next    = ST_EMIT;
                                    end
                                end
                                else
                                begin
                                    req.rd_en     = 1'b1;
                                    req.addr      = pfdr_pkg::mem_addr(
                                        8'(stat.pos - pfdr_pkg::POS_W'(3)), stat.page);
                                    res_data_next = 1'b1;
                                    state_next    = ST_READ;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RMW:
            begin
                req.wr_en   = 1'b1;
                req.addr    = pix_addr_reg;
                req.wr_data = pix_set_reg ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
                state_next  = ST_IDLE;
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    load_byte  = rd_data;
                    load_data  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    res_byte_next = rd_data;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_addr_reg <= pix_addr_next;
        pix_bit_reg  <= pix_bit_next;
        pix_set_reg  <= pix_set_next;
        res_byte_reg <= res_byte_next;
        res_data_reg <= res_data_next;
        res_last_reg <= res_last_next;
        if (load)
        begin
            stream_byte_reg <= load_byte;
            is_data_reg     <= load_data;
            last_reg        <= load_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign stream_byte     = stream_byte_reg;
    assign is_data         = is_data_reg;
    assign last_of_refresh = last_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("Control state is not one-hot.");

    a_rmw_returns: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RMW |=> state_reg == ST_IDLE)
        else $error("Pixel write back did not return to idle.");

    a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> state_reg != ST_CLEAR && state_reg != ST_RMW)
        else $error("Output loaded outside a stream byte.");

endmodule

// ===== hw/rtl/pfdr_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame store
// Single-port synchronous byte memory with registered read data and a
// clearing sweep that runs after reset and on request.
// ----------------------------------------------------------------------------
module pfdr_store
(
    input  logic                clk,
    input  logic                rst_n,
    input  pfdr_pkg::mem_req_t  req,
    input  logic                clear_start,
    output logic [7:0]          rd_data,
    output logic                busy
);

    logic [7:0]                  mem_reg [pfdr_pkg::DEPTH];
    logic [7:0]                  rd_data_reg;
    logic                        sweep_active_reg;
    logic                        sweep_active_next;
    logic [pfdr_pkg::ADDR_W-1:0] sweep_addr_reg;
    logic [pfdr_pkg::ADDR_W-1:0] sweep_addr_next;

    always_comb
    begin
        sweep_active_next = sweep_active_reg;
        sweep_addr_next   = sweep_addr_reg;
        if (clear_start)
        begin
            sweep_active_next = 1'b1;
            sweep_addr_next   = '0;
        end
        else if (sweep_active_reg)
        begin
            if (sweep_addr_reg == pfdr_pkg::ADDR_W'(pfdr_pkg::DEPTH - 1))
            begin
                sweep_active_next = 1'b0;
            end
            sweep_addr_next = sweep_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_active_reg <= 1'b1;
            sweep_addr_reg   <= '0;
        end
        else
        begin
            sweep_active_reg <= sweep_active_next;
            sweep_addr_reg   <= sweep_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sweep_active_reg)
        begin
            mem_reg[sweep_addr_reg] <= 8'h00;
        end
        else if (req.wr_en)
        begin
            mem_reg[req.addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem_reg[req.addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = sweep_active_reg;

    a_no_access_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_active_reg |-> !req.rd_en && !req.wr_en)
        else $error("Store accessed during clearing sweep.");

endmodule

// ===== hw/rtl/pfdr_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Refresh sequencer
// Holds the dirty pages, the first-refresh flag and the latched page mask,
// and walks the page and byte position of the refresh stream.
// ----------------------------------------------------------------------------
module pfdr_seq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfdr_pkg::seq_cmd_t   cmd,
    output pfdr_pkg::seq_stat_t  stat
);

    logic [7:0]                 dirty_reg;
    logic [7:0]                 dirty_next;
    logic                       first_reg;
    logic                       first_next;
    logic [7:0]                 mask_reg;
    logic [7:0]                 mask_next;
    logic                       active_reg;
    logic                       active_next;
    logic [2:0]                 page_reg;
    logic [2:0]                 page_next;
    logic [pfdr_pkg::POS_W-1:0] pos_reg;
    logic [pfdr_pkg::POS_W-1:0] pos_next;
    logic [7:0]                 start_mask;
    pfdr_pkg::page_sel_t        start_sel;
    pfdr_pkg::page_sel_t        adv_sel;
    logic                       at_end;

    assign start_mask = first_reg ? pfdr_pkg::ALL_PAGES : (dirty_reg & pfdr_pkg::ALL_PAGES);
    assign start_sel  = pfdr_pkg::next_page(start_mask, 4'd0);
    assign adv_sel    = pfdr_pkg::next_page(mask_reg, {1'b0, page_reg} + 4'd1);
    assign at_end     = (pos_reg == pfdr_pkg::POS_W'(pfdr_pkg::LAST_POS));

    always_comb
    begin
        dirty_next  = dirty_reg;
        first_next  = first_reg;
        mask_next   = mask_reg;
        active_next = active_reg;
        page_next   = page_reg;
        pos_next    = pos_reg;
        priority if (cmd.clear_all)
        begin
            mask_next   = pfdr_pkg::ALL_PAGES;
            first_next  = 1'b0;
            dirty_next  = 8'h00;
            pos_next    = '0;
            active_next = 1'b1;
            page_next   = 3'd0;
        end
        else if (cmd.start)
        begin
            mask_next   = start_mask;
            first_next  = 1'b0;
            dirty_next  = 8'h00;
            pos_next    = '0;
            active_next = start_sel.found;
            page_next   = start_sel.found ? start_sel.page : 3'd0;
        end
        else if (cmd.advance)
        begin
            if (at_end)
            begin
                pos_next = '0;
                if (adv_sel.found)
                begin
                    page_next = adv_sel.page;
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        else if (cmd.mark)
        begin
            dirty_next = dirty_reg | (8'd1 << cmd.mark_page);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg  <= 8'h00;
            first_reg  <= 1'b1;
            mask_reg   <= 8'h00;
            active_reg <= 1'b0;
            page_reg   <= 3'd0;
            pos_reg    <= '0;
        end
        else
        begin
            dirty_reg  <= dirty_next;
            first_reg  <= first_next;
            mask_reg   <= mask_next;
            active_reg <= active_next;
            page_reg   <= page_next;
            pos_reg    <= pos_next;
        end
    end

    assign stat.active = active_reg;
    assign stat.page   = page_reg;
    assign stat.pos    = pos_reg;
    assign stat.last   = at_end && !adv_sel.found;

    a_page_selected: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> mask_reg[page_reg])
        else $error("Refresh page is not in the latched mask.");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= pfdr_pkg::POS_W'(pfdr_pkg::LAST_POS))
        else $error("Refresh position beyond the end of a page.");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame buffer refresh testbench
// Feeds pixel, clear-all, start-refresh and next-byte items into the frame
// buffer. A shadow copy of the store, the dirty pages and the refresh cursor
// predicts every stream byte, and each byte that leaves the block is checked
// against the oldest prediction. Both channels idle at random, the receiver
// holds off once for a long stretch, and the sender pauses once until every
// predicted byte has come.
// ----------------------------------------------------------------------------
module tb;

    localparam int PAGE_BYTES    = pfdr_pkg::COLUMNS + 3;
    localparam int RANDOM_OPS    = 1600;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT_BYTE  = 200;
    localparam logic [2:0] FIRST_SPARE_ACT = 3'(pfdr_pkg::ACT_NEXT_BYTE) + 3'd1;
    localparam logic [2:0] LAST_SPARE_ACT  = 3'b111;

    typedef struct {
        logic [2:0] act;
        logic [7:0] col;
        logic [7:0] row;
    } panel_op_t;

    typedef struct {
        logic [7:0] value;
        logic       is_data;
        logic       last;
    } stream_beat_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] action;
    logic [7:0] pixel_column;
    logic [7:0] pixel_row;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] stream_byte;
    logic       is_data;
    logic       last_of_refresh;

    panel_op_t    op_backlog[$];
    stream_beat_t expected_beats[$];
    panel_op_t    next_op;

    logic [7:0] shadow_store [pfdr_pkg::DEPTH];
    logic [7:0] dirty_mask;
    logic [7:0] latched_mask;
    logic       first_pending;
    logic       run_active;
    logic [2:0] run_page;
    int         run_pos;

    logic item_taken = 1'b0;
    logic steady     = 1'b0;
    logic hold_used  = 1'b0;
    int   hold_left  = 0;
    int   items_taken = 0;
    int   bytes_seen  = 0;
    int   runs_done   = 0;
    int   ops_queued  = 0;
    int   errors      = 0;
    int   cycle_count;

    page_framebuffer_dirty_refresh uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .pixel_column    (pixel_column),
        .pixel_row       (pixel_row),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .stream_byte     (stream_byte),
        .is_data         (is_data),
        .last_of_refresh (last_of_refresh)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int first_selected(input int from);
        for (int p = from; p < pfdr_pkg::PAGES; p++)
        begin
            if (latched_mask[p])
                return p;
        end
        return pfdr_pkg::PAGES;
    endfunction

    task automatic latch_refresh();
        int nx;
        latched_mask  = first_pending ? pfdr_pkg::ALL_PAGES
                                      : (dirty_mask & pfdr_pkg::ALL_PAGES);
        first_pending = 1'b0;
        dirty_mask    = '0;
        run_pos       = 0;
        nx            = first_selected(0);
        run_active    = nx < pfdr_pkg::PAGES;
        run_page      = run_active ? 3'(nx) : 3'd0;
    endtask

    task automatic apply_action(input logic [2:0] act, input int col, input int row);
        int           nx;
        int           col_idx;
        stream_beat_t beat;
        case (act)
            pfdr_pkg::ACT_SET_PIXEL, pfdr_pkg::ACT_CLEAR_PIXEL:
            begin
                if (col < pfdr_pkg::COLUMNS && row < pfdr_pkg::ROWS)
                begin
                    shadow_store[col * pfdr_pkg::PAGES + row / 8][row % 8] =
                        (act == pfdr_pkg::ACT_SET_PIXEL);
                    dirty_mask[row / 8] = 1'b1;
                end
            end
            pfdr_pkg::ACT_CLEAR_ALL:
            begin
                foreach (shadow_store[i])
                    shadow_store[i] = '0;
                dirty_mask    = pfdr_pkg::ALL_PAGES;
                first_pending = 1'b1;
                latch_refresh();
            end
            pfdr_pkg::ACT_START:
                latch_refresh();
            pfdr_pkg::ACT_NEXT_BYTE:
            begin
                if (run_active)
                begin
                    beat.last = 1'b0;
                    if (run_pos == 0)
                    begin
                        beat.value   = pfdr_pkg::PAGE_CMD_BASE + 8'(run_page);
                        beat.is_data = 1'b0;
                    end
                    else if (run_pos == 1)
                    begin
                        beat.value   = pfdr_pkg::COL_LOW_CMD;
                        beat.is_data = 1'b0;
                    end
                    else if (run_pos == 2)
                    begin
                        beat.value   = pfdr_pkg::COL_HIGH_CMD;
                        beat.is_data = 1'b0;
                    end
                    else
                    begin
                        col_idx = run_pos - 3;
                        if (col_idx >= pfdr_pkg::COLUMNS)
                            col_idx = pfdr_pkg::COLUMNS - 1;
                        beat.value   = shadow_store[col_idx * pfdr_pkg::PAGES + run_page];
                        beat.is_data = 1'b1;
                    end
                    if (run_pos + 1 >= PAGE_BYTES)
                    begin
                        nx      = first_selected(int'(run_page) + 1);
                        run_pos = 0;
                        if (nx < pfdr_pkg::PAGES)
                            run_page = 3'(nx);
                        else
                        begin
                            run_active = 1'b0;
                            beat.last  = 1'b1;
                        end
                    end
                    else
                        run_pos++;
                    expected_beats.push_back(beat);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic logic [2:0] pixel_act();
        return ($urandom_range(0, 99) < 70) ? pfdr_pkg::ACT_SET_PIXEL
                                            : pfdr_pkg::ACT_CLEAR_PIXEL;
    endfunction

    task automatic queue_op(input logic [2:0] act, input int col, input int row);
        panel_op_t op;
        op.act = act;
        op.col = 8'(col);
        op.row = 8'(row);
        op_backlog.push_back(op);
        if (act <= pfdr_pkg::ACT_NEXT_BYTE
            && !(act <= pfdr_pkg::ACT_CLEAR_PIXEL
                 && (col >= pfdr_pkg::COLUMNS || row >= pfdr_pkg::ROWS)))
            ops_queued++;
    endtask

    task automatic queue_pixel(input int pg);
        queue_op(pixel_act(), $urandom_range(0, pfdr_pkg::COLUMNS - 1),
                 pg * 8 + $urandom_range(0, 7));
    endtask

    task automatic wait_quiet();
        while (op_backlog.size() != 0 || in_valid || expected_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || item_taken)
        begin
            if (op_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 20))
            begin
                next_op = op_backlog.pop_front();
                in_valid     <= 1'b1;
                action       <= next_op.act;
                pixel_column <= next_op.col;
                pixel_row    <= next_op.row;
            end
            else
                in_valid <= 1'b0;
        end
        item_taken = 1'b0;
    end

    always @(negedge clk)
    begin
        if (!hold_used && bytes_seen >= HOLD_AT_BYTE)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= steady || $urandom_range(0, 99) >= 20;
    end

    always @(posedge clk)
    begin
        stream_beat_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                bytes_seen++;
                if (last_of_refresh)
                    runs_done++;
                if (expected_beats.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected byte, expected none, actual %0h",
                             $time, stream_byte);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (stream_byte !== want.value)
                        report_mismatch("stream_byte", int'(want.value),
                                        int'(stream_byte));
                    if (is_data !== want.is_data)
                        report_mismatch("is_data", int'(want.is_data), int'(is_data));
                    if (last_of_refresh !== want.last)
                        report_mismatch("last_of_refresh", int'(want.last),
                                        int'(last_of_refresh));
                end
            end
            if (in_valid && in_ready)
            begin
                apply_action(action, int'(pixel_column), int'(pixel_row));
                item_taken = 1'b1;
                items_taken++;
                steady = items_taken >= 600 && items_taken < 1000;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped at the limit of %0d cycles.", CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int n_pages;
        int page_a;
        int page_b;
        int pg;
        int span;
        int roll;
        int frame;
        int clear_frame;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = pfdr_pkg::ACT_NEXT_BYTE;
        pixel_column = '0;
        pixel_row    = '0;
        out_ready    = 1'b0;
        foreach (shadow_store[i])
            shadow_store[i] = '0;
        dirty_mask    = '0;
        latched_mask  = '0;
        first_pending = 1'b1;
        run_active    = 1'b0;
        run_page      = '0;
        run_pos       = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_op(pfdr_pkg::ACT_NEXT_BYTE, 0, 0);
        queue_op(pfdr_pkg::ACT_CLEAR_ALL, 0, 0);
        queue_op(pfdr_pkg::ACT_NEXT_BYTE, 0, 0);
        queue_op(pfdr_pkg::ACT_NEXT_BYTE, 0, 0);
        queue_op(pfdr_pkg::ACT_SET_PIXEL, 0, 0);
        queue_op(pfdr_pkg::ACT_SET_PIXEL, pfdr_pkg::COLUMNS - 1, pfdr_pkg::ROWS - 1);
        queue_op(pfdr_pkg::ACT_SET_PIXEL, pfdr_pkg::COLUMNS - 1, pfdr_pkg::ROWS - 2);
        queue_op(pfdr_pkg::ACT_CLEAR_PIXEL, pfdr_pkg::COLUMNS - 1, pfdr_pkg::ROWS - 2);
        queue_op(pfdr_pkg::ACT_CLEAR_PIXEL, 5, 5);
        queue_op(pfdr_pkg::ACT_SET_PIXEL, pfdr_pkg::COLUMNS, 0);
        queue_op(pfdr_pkg::ACT_SET_PIXEL, 0, pfdr_pkg::ROWS);
        queue_op(pfdr_pkg::ACT_CLEAR_PIXEL, 255, 255);
        for (int a = FIRST_SPARE_ACT; a <= LAST_SPARE_ACT; a++)
            queue_op(3'(a), 255, 255);
        queue_op(pfdr_pkg::ACT_START, 0, 0);
        repeat (4) queue_op(pfdr_pkg::ACT_NEXT_BYTE, 255, 255);
        queue_op(pfdr_pkg::ACT_SET_PIXEL, 3, 9);
        queue_op(pfdr_pkg::ACT_START, 0, 0);
        repeat (3) queue_op(pfdr_pkg::ACT_NEXT_BYTE, 0, 0);

        // The sender stays quiet here until every byte of the directed part is back.
        wait_quiet();

        ops_queued  = 0;
        frame       = 0;
        clear_frame = $urandom_range(1, 5);
        while (ops_queued < RANDOM_OPS)
        begin
            if (frame == clear_frame)
            begin
                queue_op(pfdr_pkg::ACT_CLEAR_ALL, $urandom_range(0, 255),
                         $urandom_range(0, 255));
                repeat ($urandom_range(40, 300))
                    queue_op(pfdr_pkg::ACT_NEXT_BYTE, $urandom_range(0, 255),
                             $urandom_range(0, 255));
            end
            page_a  = $urandom_range(0, pfdr_pkg::PAGES - 1);
            page_b  = $urandom_range(0, pfdr_pkg::PAGES - 1);
            n_pages = ($urandom_range(0, 9) < 7 || page_a == page_b) ? 1 : 2;
            repeat ($urandom_range(2, 8))
            begin
                pg   = (n_pages == 2 && $urandom_range(0, 1) == 1) ? page_b : page_a;
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    queue_op(pixel_act(), $urandom_range(pfdr_pkg::COLUMNS, 255),
                             $urandom_range(0, 255));
                else if (roll < 15)
                    queue_op(pixel_act(), $urandom_range(0, 255),
                             $urandom_range(pfdr_pkg::ROWS, 255));
                else if (roll < 22)
                    queue_op(3'($urandom_range(FIRST_SPARE_ACT, LAST_SPARE_ACT)),
                             $urandom_range(0, 255), $urandom_range(0, 255));
                else
                    queue_pixel(pg);
            end
            queue_op(pfdr_pkg::ACT_START, $urandom_range(0, 255), $urandom_range(0, 255));
            span = n_pages * PAGE_BYTES;
            if ($urandom_range(0, 99) < 15)
                span = $urandom_range(1, span - 1);
            else
                span += $urandom_range(0, 3);
            for (int k = 0; k < span; k++)
            begin
                if ($urandom_range(0, 99) < 2)
                    queue_pixel($urandom_range(0, pfdr_pkg::PAGES - 1));
                queue_op(pfdr_pkg::ACT_NEXT_BYTE, $urandom_range(0, 255),
                         $urandom_range(0, 255));
            end
            frame++;
        end

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Accepted %0d items in %0d refresh frames after the directed part.",
                 items_taken, frame);
        $display("Checked %0d stream bytes across %0d completed refresh runs.",
                 bytes_seen, runs_done);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pfdr_pkg.sv
hw/rtl/pfdr_store.sv
hw/rtl/pfdr_seq.sv
hw/rtl/page_framebuffer_dirty_refresh.sv
test/tb.sv
